// ===== design/hit_or_miss_3x3_stream_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Hit-or-miss 3x3 stream unit: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HIT_OR_MISS_3X3_STREAM_UNIT_DEFINES_SVH
`define HIT_OR_MISS_3X3_STREAM_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HOM_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HOM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/hom_pkg.sv =====
// ----------------------------------------------------------------------------
// Hit-or-miss 3x3 package
// Pixel classes, window and word types, register indexes and the match logic.
// ----------------------------------------------------------------------------
package hom_pkg;

   // Two-bit pixel class kept in the line buffers and the window.
   typedef logic [1:0] pix_class_type;

   localparam pix_class_type CLASS_OUT   = 2'd0;  // outside the image
   localparam pix_class_type CLASS_ZERO  = 2'd1;  // gray level 0
   localparam pix_class_type CLASS_FULL  = 2'd2;  // gray level 255
   localparam pix_class_type CLASS_OTHER = 2'd3;  // any other level

   // One window column, index 0 is the top row.
   typedef pix_class_type [2:0] win_col_type;

   // Full window, entry v*3+u is row v, column u.
   typedef pix_class_type [8:0] win_type;

   // Configuration register indexes.
   typedef logic [1:0] csr_index_type;

   localparam csr_index_type REG_FRAME_WIDTH  = 2'd0;
   localparam csr_index_type REG_FRAME_HEIGHT = 2'd1;
   localparam csr_index_type REG_HIT_PATTERN  = 2'd2;
   localparam csr_index_type REG_MISS_PATTERN = 2'd3;

   localparam int CSR_DATA_W = 11;
   localparam int PATTERN_W  = 9;

   // Reset values of the configuration registers.
   localparam logic [CSR_DATA_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RESET = 11'd480;
   localparam logic [PATTERN_W-1:0]  HIT_PATTERN_RESET  = 9'd23;
   localparam logic [PATTERN_W-1:0]  MISS_PATTERN_RESET = 9'd448;

   localparam logic [7:0] MATCH_ON  = 8'd255;
   localparam logic [7:0] MATCH_OFF = 8'd0;
   localparam logic [7:0] GRAY_FULL = 8'd255;
   localparam logic [7:0] GRAY_ZERO = 8'd0;

   // Result queue geometry.
   localparam int RSP_PTR_W = 3;
   localparam int RSP_DEPTH = 1 << RSP_PTR_W;
   localparam int RSP_LVL_W = RSP_PTR_W + 1;

   // Item as it leaves the counter stage for the window stage.
   typedef struct packed {
      logic          col_zero;
      logic          row_ge1;
      logic          row_ge2;
      logic          rowend;
      logic          draining;
      pix_class_type bot;
   } stage_item_type;

   // One result word.
   typedef struct packed {
      logic [7:0] match_value;
      logic       last_of_run;
      logic       end_of_frame;
   } rsp_word_type;

   // Result queue status toward the top level.
   typedef struct packed {
      logic [RSP_LVL_W-1:0] level;
   } rsp_status_type;

   // Map a gray level to its class.
   function automatic pix_class_type classify(input logic [7:0] gray);
      pix_class_type c;
      if (gray == GRAY_ZERO) c = CLASS_ZERO;
      else if (gray == GRAY_FULL) c = CLASS_FULL;
      else c = CLASS_OTHER;
      return c;
   endfunction

   // Both tests over all nine positions; each position is checked on its own.
   function automatic logic judge(input win_type win,
                                  input logic [PATTERN_W-1:0] hit,
                                  input logic [PATTERN_W-1:0] miss);
      logic ok;
      ok = 1'b1;
      for (int k = 0; k < 9; k++) begin
         if (hit[k] ? (win[k] != CLASS_FULL)
                    : (win[k] == CLASS_FULL || win[k] == CLASS_OTHER)) ok = 1'b0;
         if (miss[k] ? (win[k] != CLASS_ZERO) : (win[k] == CLASS_ZERO)) ok = 1'b0;
      end
      return ok;
   endfunction

endpackage

// ===== design/hom_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hom_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/hom_window.sv =====
// ----------------------------------------------------------------------------
// Hit-or-miss window stage
// Shifts the 3x3 class window and judges the center and row-end positions.
// ----------------------------------------------------------------------------
module hom_window
   import hom_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  stage_item_type       item,
   input  pix_class_type        upper_cls,
   input  pix_class_type        middle_cls,
   input  logic [PATTERN_W-1:0] hit_pattern,
   input  logic [PATTERN_W-1:0] miss_pattern,
   output logic [1:0]           push_count,
   output rsp_word_type         push_word0,
   output rsp_word_type         push_word1
);

   win_col_type win_center_ff, win_center_in;
   win_col_type win_right_ff,  win_right_in;
   win_col_type new_left;
   win_type     main_win;
   win_type     edge_win;
   logic        main_valid;
   logic        edge_valid;
   logic        main_hit;
   logic        edge_hit;

   // New window: a row start clears the older columns.
   always_comb begin
      new_left      = item.col_zero ? '0 : win_center_ff;
      win_center_in = item.col_zero ? '0 : win_right_ff;
      win_right_in[0] = item.row_ge2 ? upper_cls  : CLASS_OUT;
      win_right_in[1] = item.row_ge1 ? middle_cls : CLASS_OUT;
      win_right_in[2] = item.bot;
      for (int v = 0; v < 3; v++) begin
         main_win[v*3+0] = new_left[v];
         main_win[v*3+1] = win_center_in[v];
         main_win[v*3+2] = win_right_in[v];
         edge_win[v*3+0] = win_center_in[v];
         edge_win[v*3+1] = win_right_in[v];
         edge_win[v*3+2] = CLASS_OUT;
      end
   end

   // Window registers advance with every item.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_center_ff <= '0;
         win_right_ff  <= '0;
      end else if (item_valid) begin
         win_center_ff <= win_center_in;
         win_right_ff  <= win_right_in;
      end
   end

   // Both judgments run side by side.
   assign main_hit   = judge(main_win, hit_pattern, miss_pattern);
   assign edge_hit   = judge(edge_win, hit_pattern, miss_pattern);
   assign main_valid = item_valid && item.row_ge1 && !item.col_zero;
   assign edge_valid = item_valid && item.row_ge1 && item.rowend;

   // Pack the results in order; the final one carries the last flag.
   always_comb begin
      push_count = 2'd0;
      push_word0 = '0;
      push_word1 = '0;
      if (main_valid && edge_valid) begin
         push_count              = 2'd2;
         push_word0.match_value  = main_hit ? MATCH_ON : MATCH_OFF;
         push_word1.match_value  = edge_hit ? MATCH_ON : MATCH_OFF;
         push_word1.last_of_run  = 1'b1;
         push_word1.end_of_frame = item.draining;
      end else if (main_valid) begin
         push_count              = 2'd1;
         push_word0.match_value  = main_hit ? MATCH_ON : MATCH_OFF;
         push_word0.last_of_run  = 1'b1;
      end else if (edge_valid) begin
         push_count              = 2'd1;
         push_word0.match_value  = edge_hit ? MATCH_ON : MATCH_OFF;
         push_word0.last_of_run  = 1'b1;
         push_word0.end_of_frame = item.draining;
      end
   end

endmodule

// ===== design/hom_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// Hit-or-miss result queue
// Small queue that takes up to two words a cycle and hands out one.
// ----------------------------------------------------------------------------
module hom_rsp_fifo
   import hom_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [1:0]     push_count,
   input  rsp_word_type   push_word0,
   input  rsp_word_type   push_word1,
   input  logic           pop,
   output logic           out_valid,
   output rsp_word_type   out_word,
   output rsp_status_type status
);

   rsp_word_type           mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wptr_ff, wptr_in;
   logic [RSP_PTR_W-1:0]   rptr_ff, rptr_in;
   logic [RSP_LVL_W-1:0]   level_ff, level_in;
   logic [RSP_PTR_W-1:0]   wptr_next;
   logic                   do_pop;

   assign out_valid = level_ff != '0;
   assign out_word  = mem_ff[rptr_ff];
   assign do_pop    = pop && out_valid;
   assign wptr_next = wptr_ff + RSP_PTR_W'(1);

   // Store the pushed words in order.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) mem_ff[wptr_ff] <= push_word0;
      if (push_count == 2'd2) mem_ff[wptr_next] <= push_word1;
   end

   // Pointer and fill level.
   always_comb begin
      wptr_in  = wptr_ff + RSP_PTR_W'(push_count);
      rptr_in  = rptr_ff + (do_pop ? RSP_PTR_W'(1) : '0);
      level_in = level_ff + RSP_LVL_W'(push_count) - (do_pop ? RSP_LVL_W'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         level_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         level_ff <= level_in;
      end
   end

   assign status.level = level_ff;

endmodule

// ===== design/hit_or_miss_3x3_stream_unit.sv =====
// The results caused by an accepted word are registered in the item stage and then in
// the result queue before they are offered on rsp. Throughput: one input word per clock,
// set by the line RAM read-modify-write loop, while req_tready is high; a row-end word
// can yield two results; the result side drains one word per clock while rsp_tready is
// high. req_tready drops when the eight-word result queue cannot absorb words in flight.
// Reset: synchronous, clears counters, window, queue and sets registers to defaults;
// ----------------------------------------------------------------------------
// Hit-or-miss 3x3 stream unit
// Streams a gray image through two line buffers in one RAM and a 3x3 window,
// and gives the hit-or-miss result for every pixel. The line RAM is not cleared
// at reset and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "hit_or_miss_3x3_stream_unit_defines.svh"

module hit_or_miss_3x3_stream_unit
   import hom_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] gray_value
   input  logic                  req_tuser,   // [0] req_type
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] match_value
   output logic                  rsp_tlast,
   output logic                  rsp_tuser,   // [0] end_of_frame
   // Configuration port.
   input  logic                  csr_wen,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = CW + 1;
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [CSR_DATA_W-1:0] frame_width_ff;
   logic [CSR_DATA_W-1:0] frame_height_ff;
   logic [PATTERN_W-1:0]  hit_pattern_ff;
   logic [PATTERN_W-1:0]  miss_pattern_ff;

   logic [WW-1:0]  width_eff;
   logic [HW-1:0]  height_eff;
   logic [CW-1:0]  col_ff, col_in;
   logic [HW-1:0]  row_ff, row_in;
   logic           draining;
   logic           rowend;
   logic           ignored;
   logic           req_accept;
   logic           item_take;

   logic           s1_valid_ff, s1_valid_in;
   stage_item_type s1_item_ff,  s1_item_in;
   logic [CW-1:0]  s1_col_ff;
   logic           s1_we_ff;

   logic [3:0]     ram_rd_data;
   logic [3:0]     line_rd;
   logic [3:0]     ram_wr_data;
   logic           ram_wr_en;
   logic           fwd_ff, fwd_in;
   logic [3:0]     fwd_data_ff;

   logic [1:0]     push_count;
   rsp_word_type   push_word0;
   rsp_word_type   push_word1;
   rsp_word_type   out_word;
   rsp_status_type rsp_status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         hit_pattern_ff  <= HIT_PATTERN_RESET;
         miss_pattern_ff <= MISS_PATTERN_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            REG_HIT_PATTERN:  hit_pattern_ff  <= csr_wdata[PATTERN_W-1:0];
            REG_MISS_PATTERN: miss_pattern_ff <= csr_wdata[PATTERN_W-1:0];
         endcase
      end
   end

   // Frame size clamped to the supported range.
   always_comb begin
      if (frame_width_ff == '0) width_eff = WW'(1);
      else if (32'(frame_width_ff) > MAX_WIDTH) width_eff = WW'(MAX_WIDTH);
      else width_eff = WW'(frame_width_ff);
      if (frame_height_ff == '0) height_eff = HW'(1);
      else if (32'(frame_height_ff) > MAX_HEIGHT) height_eff = HW'(MAX_HEIGHT);
      else height_eff = HW'(frame_height_ff);
   end

   // Position decode; an early drain word is dropped without effect.
   assign draining   = row_ff >= height_eff;
   assign rowend     = (WW'(col_ff) + WW'(1)) >= width_eff;
   assign ignored    = !draining && req_tuser;
   assign req_accept = req_tvalid && req_tready;
   assign item_take  = req_accept && !ignored;

   // Leave room in the result queue for every word still in flight.
   assign req_tready = (5'(rsp_status.level) + (s1_valid_ff ? 5'd2 : 5'd0))
                       <= 5'(RSP_DEPTH - 2);

   // Column and row counters.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (item_take) begin
         if (rowend) begin
            col_in = '0;
            row_in = draining ? '0 : row_ff + HW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Item handed to the window stage while the line RAM read is in flight.
   always_comb begin
      s1_valid_in         = item_take;
      s1_item_in.col_zero = col_ff == '0;
      s1_item_in.row_ge1  = row_ff != '0;
      s1_item_in.row_ge2  = row_ff > HW'(1);
      s1_item_in.rowend   = rowend;
      s1_item_in.draining = draining;
      s1_item_in.bot      = draining ? CLASS_OUT : classify(req_tdata);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         s1_item_ff <= s1_item_in;
         s1_col_ff  <= col_ff;
         s1_we_ff   <= !draining;
      end
   end

   // Line RAM: upper line in bits 3:2, middle line in bits 1:0.
   hom_ram #(
      .WIDTH (4),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (ram_wr_data),
      .rd_en   (item_take),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // Forward a write that hit the same column as the read just issued.
   assign line_rd     = fwd_ff ? fwd_data_ff : ram_rd_data;
   assign ram_wr_en   = s1_valid_ff && s1_we_ff;
   assign ram_wr_data = {line_rd[1:0], s1_item_ff.bot};
   assign fwd_in      = ram_wr_en && item_take && (col_ff == s1_col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fwd_in) begin
         fwd_data_ff <= ram_wr_data;
      end
   end

   // Window and match.
   hom_window u_window (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (s1_valid_ff),
      .item         (s1_item_ff),
      .upper_cls    (line_rd[3:2]),
      .middle_cls   (line_rd[1:0]),
      .hit_pattern  (hit_pattern_ff),
      .miss_pattern (miss_pattern_ff),
      .push_count   (push_count),
      .push_word0   (push_word0),
      .push_word1   (push_word1)
   );

   // Result queue toward the output channel.
   hom_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_word0 (push_word0),
      .push_word1 (push_word1),
      .pop        (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_word   (out_word),
      .status     (rsp_status)
   );

   assign rsp_tdata = out_word.match_value;
   assign rsp_tlast = out_word.last_of_run;
   assign rsp_tuser = out_word.end_of_frame;

   // Checks on queue sizing, forwarding, end-of-frame marking and frame restart.
   `HOM_ASSERT_IMPLIES(a_rsp_no_overflow, 1'b1, rsp_status.level <= RSP_LVL_W'(RSP_DEPTH), "result queue overflow")
   `HOM_ASSERT_IMPLIES(a_fwd_has_item, fwd_ff, s1_valid_ff, "forwarded line data without an item")
   `HOM_ASSERT_IMPLIES(a_eof_is_last, rsp_tvalid && rsp_tuser, rsp_tlast, "end of frame result not last")
   `HOM_ASSERT_NEXT(a_frame_restart, item_take && draining && rowend, row_ff == '0 && col_ff == '0, "no restart after drain row")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Hit-or-miss 3x3 stream unit testbench
// Streams gray frames of many shapes and masks through the unit. A scoreboard
// class predicts every result word from its own copy of the line buffers and
// the window and compares each accepted word with the oldest prediction.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hom_pkg::*;

   localparam int WIDTH_CAP    = 1024;
   localparam int HEIGHT_CAP   = 1024;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int SETTLE       = 8;
   localparam int RANDOM_WORDS = 1125;
   localparam int PRINT_CAP    = 20;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef enum int {IMG_NOISE, IMG_BINARY, IMG_TILE, IMG_FLAT} image_kind_type;

   // Predicts result words from accepted input words and checks the output.
   class scoreboard_type;
      logic [CSR_DATA_W-1:0] width_reg, height_reg;
      logic [PATTERN_W-1:0]  hit_mask, miss_mask;
      pix_class_type         upper[WIDTH_CAP];
      pix_class_type         middle[WIDTH_CAP];
      win_type               win;
      int unsigned           col, row;
      rsp_word_type          expected_q[$];
      int                    errors, checked, match_count;

      function new();
         width_reg  = FRAME_WIDTH_RESET;
         height_reg = FRAME_HEIGHT_RESET;
         hit_mask   = HIT_PATTERN_RESET;
         miss_mask  = MISS_PATTERN_RESET;
         foreach (upper[i]) begin
            upper[i]  = CLASS_OUT;
            middle[i] = CLASS_OUT;
         end
         win = {9{CLASS_OUT}};
         col = 0;
         row = 0;
         errors = 0;
         checked = 0;
         match_count = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_FRAME_WIDTH:  width_reg  = value;
            REG_FRAME_HEIGHT: height_reg = value;
            REG_HIT_PATTERN:  hit_mask   = value[PATTERN_W-1:0];
            REG_MISS_PATTERN: miss_mask  = value[PATTERN_W-1:0];
            default: ;
         endcase
      endfunction

      function void report_mismatch(string msg);
         errors++;
         if (errors <= PRINT_CAP) $display("MISMATCH: %s", msg);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function pix_class_type class_of(logic [7:0] gray);
         case (gray)
            GRAY_ZERO: return CLASS_ZERO;
            GRAY_FULL: return CLASS_FULL;
            default:   return CLASS_OTHER;
         endcase
      endfunction

      // Each position demands one class: full where only the hit bit is set,
      // zero where only the miss bit is set, outside where neither is set.
      // A position with both bits set can never match.
      function logic [7:0] window_result(win_type w);
         pix_class_type need;
         for (int k = 0; k < 9; k++) begin
            if (hit_mask[k] && miss_mask[k]) return MATCH_OFF;
            need = hit_mask[k] ? CLASS_FULL : (miss_mask[k] ? CLASS_ZERO : CLASS_OUT);
            if (w[k] != need) return MATCH_OFF;
         end
         return MATCH_ON;
      endfunction

      // Advance the predicted state by one accepted input word.
      function void note_word(logic kind, logic [7:0] gray);
         int unsigned   w, h, c;
         bit            draining, rowend;
         pix_class_type top, mid, bot;
         win_type       side_win;
         w = (width_reg == 0) ? 1 : ((width_reg > WIDTH_CAP) ? WIDTH_CAP : width_reg);
         h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_CAP) ? HEIGHT_CAP : height_reg);
         c = col % WIDTH_CAP;
         draining = (row >= h);
         rowend = (c + 1 >= w);
         // An early drain tick leaves everything as it is.
         if (!draining && kind == KIND_DRAIN) return;
         bot = draining ? CLASS_OUT : class_of(gray);
         mid = (row >= 1) ? middle[c] : CLASS_OUT;
         top = (row >= 2) ? upper[c] : CLASS_OUT;
         if (!draining) begin
            upper[c]  = middle[c];
            middle[c] = bot;
         end
         if (c == 0) win = {9{CLASS_OUT}};
         for (int v = 0; v < 3; v++) begin
            win[v*3]   = win[v*3+1];
            win[v*3+1] = win[v*3+2];
         end
         win[2] = top;
         win[5] = mid;
         win[8] = bot;
         if (row >= 1) begin
            if (c >= 1)
               expected_q.push_back(rsp_word_type'({window_result(win), !rowend, 1'b0}));
            // The row end also closes the last column against the right border.
            if (rowend) begin
               for (int v = 0; v < 3; v++) begin
                  side_win[v*3]   = win[v*3+1];
                  side_win[v*3+1] = win[v*3+2];
                  side_win[v*3+2] = CLASS_OUT;
               end
               expected_q.push_back(rsp_word_type'({window_result(side_win), 1'b1,
                                                    draining}));
            end
         end
         if (rowend) begin
            col = 0;
            row = draining ? 0 : row + 1;
         end else begin
            col = c + 1;
         end
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word value %0d last %0b eof %0b",
                                      got.match_value, got.last_of_run, got.end_of_frame));
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.match_value == MATCH_ON) match_count++;
         if (got.match_value !== want.match_value)
            report_mismatch($sformatf("word %0d: match_value %0d, predicted %0d",
                                      checked, got.match_value, want.match_value));
         if (got.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("word %0d: last_of_run %0b, predicted %0b",
                                      checked, got.last_of_run, want.last_of_run));
         if (got.end_of_frame !== want.end_of_frame)
            report_mismatch($sformatf("word %0d: end_of_frame %0b, predicted %0b",
                                      checked, got.end_of_frame, want.end_of_frame));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'd0;   // [7:0] gray_value
   logic                  req_tuser = 1'b0;   // [0] req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;          // [7:0] match_value
   logic                  rsp_tlast;
   logic                  rsp_tuser;          // [0] end_of_frame
   logic                  csr_wen = 1'b0;
   csr_index_type         csr_index = REG_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   scoreboard_type sb = new();
   bit             calm = 1'b0;
   int             cycle_count = 0;
   int             frames = 0, pixel_words = 0, drain_words = 0, ignored_words = 0;

   hit_or_miss_3x3_stream_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("hit_or_miss_3x3_stream_unit verification failed");
         $finish;
      end
   end

   // Both handshakes are observed here, on the values before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_word(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_word_type'({rsp_tdata, rsp_tlast, rsp_tuser}));
      end
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 20);
   endfunction

   // Result side: bursts of ready broken by random stalls.
   initial begin
      @(posedge clock);
      forever begin
         int stall;
         stall = idle_len();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat (calm ? 1 : $urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Offer one word after a random gap and hold it until it is taken.
   task automatic send_word(logic kind, logic [7:0] gray);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= gray;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop sending until every predicted word has arrived.
   task automatic wait_results_done(int extra);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_config(logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] h,
                               logic [PATTERN_W-1:0] hit, logic [PATTERN_W-1:0] miss);
      csr_wen   <= 1'b1;
      csr_index <= REG_FRAME_WIDTH;
      csr_wdata <= w;
      sb.write_reg(REG_FRAME_WIDTH, w);
      @(posedge clock);
      csr_index <= REG_FRAME_HEIGHT;
      csr_wdata <= h;
      sb.write_reg(REG_FRAME_HEIGHT, h);
      @(posedge clock);
      csr_index <= REG_HIT_PATTERN;
      csr_wdata <= CSR_DATA_W'(hit);
      sb.write_reg(REG_HIT_PATTERN, CSR_DATA_W'(hit));
      @(posedge clock);
      csr_index <= REG_MISS_PATTERN;
      csr_wdata <= CSR_DATA_W'(miss);
      sb.write_reg(REG_MISS_PATTERN, CSR_DATA_W'(miss));
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   function automatic logic [7:0] pick_gray(image_kind_type kind, logic [8:0] tile, int r,
                                            int c);
      int roll;
      roll = $urandom_range(0, 99);
      case (kind)
         IMG_NOISE:  return 8'($urandom_range(0, 255));
         IMG_BINARY: begin
            if (roll < 45) return GRAY_ZERO;
            if (roll < 90) return GRAY_FULL;
            return 8'($urandom_range(0, 255));
         end
         // The tile repeats every three rows and columns, so windows centered
         // on row 1 and column 1 modulo 3 see the tile itself.
         IMG_TILE: begin
            if (roll < 3) return 8'($urandom_range(0, 255));
            return tile[(r % 3) * 3 + (c % 3)] ? GRAY_FULL : GRAY_ZERO;
         end
         default: return tile[0] ? GRAY_FULL : GRAY_ZERO;
      endcase
   endfunction

   // One whole frame followed by its drain row, then wait for the results.
   task automatic run_frame(logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] h,
                            image_kind_type kind, logic [8:0] tile, bit early, bit squeeze);
      int ew, eh, hold_at;
      ew = (w == 0) ? 1 : ((w > WIDTH_CAP) ? WIDTH_CAP : w);
      eh = (h == 0) ? 1 : ((h > HEIGHT_CAP) ? HEIGHT_CAP : h);
      hold_at = squeeze ? $urandom_range(0, ew * eh - 1) : -1;
      for (int r = 0; r < eh; r++) begin
         for (int c = 0; c < ew; c++) begin
            // A drain tick inside the frame must be ignored.
            if (early && $urandom_range(0, 24) == 0) begin
               send_word(KIND_DRAIN, 8'($urandom_range(0, 255)));
               ignored_words++;
            end
            if (r * ew + c == hold_at) wait_results_done(0);
            send_word(KIND_PIXEL, pick_gray(kind, tile, r, c));
            pixel_words++;
         end
      end
      // Pixel words in the drain row act as drain ticks.
      for (int c = 0; c < ew; c++) begin
         if ($urandom_range(0, 3) == 0) send_word(KIND_PIXEL, 8'($urandom_range(0, 255)));
         else send_word(KIND_DRAIN, 8'($urandom_range(0, 255)));
         drain_words++;
      end
      frames++;
      wait_results_done(SETTLE);
   endtask

   // Stimulus.
   initial begin
      int             random_words, words_at_start, roll;
      logic [10:0]    w, h;
      logic [8:0]     hit, miss, tile;
      image_kind_type kind;
      bit             first;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: gray extremes in a 2x2 frame with early drain ticks.
      write_config(11'd2, 11'd2, 9'h000, 9'h1FF);
      send_word(KIND_DRAIN, 8'hA5);
      send_word(KIND_PIXEL, GRAY_ZERO);
      send_word(KIND_PIXEL, GRAY_FULL);
      send_word(KIND_DRAIN, 8'h5A);
      send_word(KIND_PIXEL, 8'd1);
      send_word(KIND_PIXEL, 8'd254);
      send_word(KIND_DRAIN, GRAY_ZERO);
      send_word(KIND_PIXEL, GRAY_FULL);
      ignored_words += 2;
      pixel_words += 4;
      drain_words += 2;
      frames++;
      wait_results_done(SETTLE);

      // Directed: a single full pixel that matches a center-only mask.
      write_config(11'd1, 11'd1, 9'h010, 9'h000);
      send_word(KIND_PIXEL, GRAY_FULL);
      send_word(KIND_DRAIN, GRAY_ZERO);
      pixel_words++;
      drain_words++;
      frames++;
      wait_results_done(SETTLE);

      // Directed: a 3x3 frame drawn from the tile, with a rare random pixel.
      write_config(11'd3, 11'd3, 9'h0B5, ~9'h0B5);
      run_frame(11'd3, 11'd3, IMG_TILE, 9'h0B5, 1'b0, 1'b0);

      // Register extremes: zero width and height act as a single pixel.
      write_config(11'd0, 11'd0, 9'h010, 9'h000);
      run_frame(11'd0, 11'd0, IMG_FLAT, 9'h1FF, 1'b1, 1'b1);

      // Random frames, mostly small, with masks chosen so that matches occur.
      random_words = 0;
      first = 1'b1;
      while (random_words < RANDOM_WORDS) begin
         calm = ($urandom_range(0, 4) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 70) w = 11'($urandom_range(1, 8));
         else if (roll < 93) w = 11'($urandom_range(9, 40));
         else if (roll < 97) w = 11'($urandom_range(41, 120));
         else w = 11'd0;
         roll = $urandom_range(0, 99);
         if (roll < 80) h = 11'($urandom_range(1, 6));
         else if (roll < 97) h = 11'($urandom_range(7, 16));
         else h = 11'd0;
         kind = image_kind_type'($urandom_range(0, 3));
         tile = 9'($urandom_range(0, 511));
         hit = 9'($urandom_range(0, 511));
         miss = 9'($urandom_range(0, 511));
         roll = $urandom_range(0, 99);
         if (kind == IMG_TILE && roll < 85) begin
            hit = tile;
            miss = ~tile;
         end else if (kind == IMG_FLAT && roll < 70) begin
            hit = tile[0] ? 9'h1FF : 9'h000;
            miss = ~hit;
         end else if (roll < 30) begin
            miss = ~hit;
         end else if (roll < 40) begin
            hit = roll[0] ? 9'h1FF : 9'h000;
            miss = roll[1] ? 9'h1FF : 9'h000;
         end
         write_config(w, h, hit, miss);
         words_at_start = pixel_words + drain_words;
         run_frame(w, h, kind, tile, $urandom_range(0, 9) < 3,
                   first || $urandom_range(0, 9) == 0);
         random_words += pixel_words + drain_words - words_at_start;
         first = 1'b0;
      end
      calm = 1'b0;

      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d predicted words never arrived", sb.pending()));
      $display("Ran %0d frames: %0d pixel words, %0d drain words, %0d early drain ticks.",
               frames, pixel_words, drain_words, ignored_words);
      $display("Checked %0d result words, %0d of them matches; %0d mismatches.",
               sb.checked, sb.match_count, sb.errors);
      if (sb.errors == 0) begin
         $display("hit_or_miss_3x3_stream_unit verification clean");
      end else begin
         $display("hit_or_miss_3x3_stream_unit verification failed");
      end
      $finish;
   end

endmodule

// ===== hit_or_miss_3x3_stream_unit.f =====
+incdir+design
design/hom_pkg.sv
design/hom_ram.sv
design/hom_window.sv
design/hom_rsp_fifo.sv
design/hit_or_miss_3x3_stream_unit.sv
tb/testbench.sv
